// ===== sv/mmbf_pkg.sv =====
// Shared types, register codes and helpers for the mipmap 2x2 box filter.
`timescale 1ns / 1ps

package mmbf_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 4;
  localparam int unsigned PixW    = ChanW * NumChan;
  localparam int unsigned SumW    = ChanW + 1;       // pair sum of one channel
  localparam int unsigned PairW   = SumW * NumChan;  // one line store entry
  localparam int unsigned QuadW   = ChanW + 2;       // 2x2 sum of one channel
  localparam int unsigned LgW     = 4;               // size register width

  // Register indexes on the config port.
  localparam logic RegWidthLog2  = 1'b0;
  localparam logic RegHeightLog2 = 1'b1;

  // Scan position flags handed from the counters to the datapath.
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_px;
  } scan_ctl_t;

  // Zero means a side of two; anything above max_lg saturates.
  function automatic logic [LgW-1:0] clamp_log2(input logic [LgW-1:0] lg,
                                                input logic [LgW-1:0] max_lg);
    logic [LgW-1:0] r;
    if (lg == '0) begin
      r = LgW'(1);
    end else if (lg > max_lg) begin
      r = max_lg;
    end else begin
      r = lg;
    end
    return r;
  endfunction

endpackage

// ===== sv/mmbf_line_store.sv =====
// Line store for even-row horizontal pair sums, one write and one read port.
`timescale 1ns / 1ps

module mmbf_line_store #(
  parameter int unsigned AW = 9,
  parameter int unsigned DW = 36
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mmbf_scan_ctl.sv =====
// Size registers and raster column/row counters of the box filter.
`timescale 1ns / 1ps

module mmbf_scan_ctl #(
  parameter int unsigned CW = 10,  // column counter bits, log2 of widest level
  parameter int unsigned RW = 9    // row counter bits, log2 of tallest level
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [mmbf_pkg::LgW-1:0] cfg_data_i,
  input  logic                     advance_i,
  output mmbf_pkg::scan_ctl_t      ctl_o,
  output logic [CW-2:0]            slot_o
);

  localparam logic [mmbf_pkg::LgW-1:0] WMaxLg = mmbf_pkg::LgW'(CW);
  localparam logic [mmbf_pkg::LgW-1:0] HMaxLg = mmbf_pkg::LgW'(RW);
  localparam logic [mmbf_pkg::LgW-1:0] WRst =
    mmbf_pkg::clamp_log2(mmbf_pkg::LgW'(10), WMaxLg);
  localparam logic [mmbf_pkg::LgW-1:0] HRst =
    mmbf_pkg::clamp_log2(mmbf_pkg::LgW'(9), HMaxLg);

  logic [mmbf_pkg::LgW-1:0] w_lg_q, w_lg_d;
  logic [mmbf_pkg::LgW-1:0] h_lg_q, h_lg_d;
  logic [CW-1:0]            col_q, col_d, w_mask;
  logic [RW-1:0]            row_q, row_d, h_mask;
  logic                     col_last, row_last;

  // last column / row index as an all-ones mask of the active size
  always_comb begin
    for (int i = 0; i < CW; i++) begin
      w_mask[i] = (i < int'(w_lg_q));
    end
    for (int j = 0; j < RW; j++) begin
      h_mask[j] = (j < int'(h_lg_q));
    end
  end

  assign col_last = (col_q == w_mask);
  assign row_last = (row_q == h_mask);

  always_comb begin
    w_lg_d = w_lg_q;
    h_lg_d = h_lg_q;
    col_d  = col_q;
    row_d  = row_q;
    priority if (cfg_we_i) begin
      // any size write restarts the level
      if (cfg_idx_i == mmbf_pkg::RegWidthLog2) begin
        w_lg_d = mmbf_pkg::clamp_log2(cfg_data_i, WMaxLg);
      end else begin
        h_lg_d = mmbf_pkg::clamp_log2(cfg_data_i, HMaxLg);
      end
      col_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end else begin
      col_d = col_q;
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_lg_q <= WRst;
      h_lg_q <= HRst;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      w_lg_q <= w_lg_d;
      h_lg_q <= h_lg_d;
      col_q  <= col_d;
      row_q  <= row_d;
    end
  end

  assign ctl_o.odd_col = col_q[0];
  assign ctl_o.odd_row = row_q[0];
  assign ctl_o.last_px = col_last && row_last;
  assign slot_o        = col_q[CW-1:1];

endmodule

// ===== sv/mipmap_box_filter_downsample_core.sv =====
// Top level: 2x2 box-filter mip level reducer for RGBA8888 pixel streams.
`timescale 1ns / 1ps

// Usage
//  - Slave stream s_axis_*: one RGBA8888 pixel per word, raster order over
//    one level of 2^width_log2 x 2^height_log2 pixels. Levels repeat back to
//    back with the same size.
//  - Master stream m_axis_*: one averaged pixel per 2x2 block, emitted on the
//    odd-column pixel of each odd row; tlast flags the level's final pixel.
//  - Config port: cfg_we_i/cfg_idx_i/cfg_data_i write width_log2 (index 0) or
//    height_log2 (index 1). A write restarts the level; write only when idle.
//    Zero acts as one, values above the parameter limits saturate.
//  - Throughput: one pixel per clock while the output is not stalled. The edge
//    that accepts the closing pixel loads the output register, so the word
//    can be taken at the next edge.
//  - Even rows store per-channel horizontal pair sums in a line store of
//    MAX_WIDTH/2 words; odd rows read the word back on the even column, so
//    the closing odd column finds it ready in the read register.
//  - Stall: one output register; while it holds an untaken word and
//    m_axis_tready is low, s_axis_tready drops.
//  - Reset: counters to zero, sizes to 10/9 (clamped), output empty. The
//    line store is not cleared; odd rows only read what the row above wrote.
module mipmap_box_filter_downsample_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [mmbf_pkg::LgW-1:0] cfg_data_i,
  // pixel input
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [mmbf_pkg::PixW-1:0] s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
  // averaged pixel output
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [mmbf_pkg::PixW-1:0] m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                     m_axis_tlast    // level_done
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1) - 1;   // floor log2
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1) - 1;
  localparam int unsigned CH = mmbf_pkg::ChanW;
  localparam int unsigned SW = mmbf_pkg::SumW;
  localparam int unsigned QW = mmbf_pkg::QuadW;

  mmbf_pkg::scan_ctl_t          ctl;
  logic [CW-2:0]                slot;
  logic                         in_accept;
  logic                         load;
  logic [mmbf_pkg::PixW-1:0]    held_q;
  logic [mmbf_pkg::PairW-1:0]   pair_sum, above;
  logic                         wr_en, rd_en;
  logic [mmbf_pkg::PixW-1:0]    avg_d, out_data_q;
  logic                         out_valid_q, out_valid_d, out_last_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mmbf_scan_ctl #(
    .CW (CW),
    .RW (RW)
  ) u_scan_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (in_accept),
    .ctl_o      (ctl),
    .slot_o     (slot)
  );

  // even column: hold the first pixel of the pair
  always_ff @(posedge clk_i) begin
    if (in_accept && !ctl.odd_col) begin
      held_q <= s_axis_tdata;
    end
  end

  // per-channel horizontal pair sums, 9 bits each
  always_comb begin
    for (int c = 0; c < mmbf_pkg::NumChan; c++) begin
      pair_sum[c*SW +: SW] = SW'(held_q[c*CH +: CH]) + SW'(s_axis_tdata[c*CH +: CH]);
    end
  end

  assign wr_en = in_accept && ctl.odd_col && !ctl.odd_row;
  assign rd_en = in_accept && !ctl.odd_col && ctl.odd_row;
  assign load  = in_accept && ctl.odd_col && ctl.odd_row;

  mmbf_line_store #(
    .AW (CW - 1),
    .DW (mmbf_pkg::PairW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (slot),
    .wdata_i (pair_sum),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (above)
  );

  // 2x2 sum, truncate by dropping two bits
  always_comb begin
    logic [QW-1:0] quad;
    for (int c = 0; c < mmbf_pkg::NumChan; c++) begin
      quad = QW'(pair_sum[c*SW +: SW]) + QW'(above[c*SW +: SW]);
      avg_d[c*CH +: CH] = quad[QW-1:2];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= avg_d;
      out_last_q <= ctl.last_px;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // no pixel is taken while an untaken result sits in the output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !in_accept)
    else $error("pixel accepted over a stalled result");

  // even widths: column parity flips with every accepted pixel
  a_col_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !cfg_we_i |=> ctl.odd_col != $past(ctl.odd_col))
    else $error("column parity did not alternate");

  // the final block of a level sends the scan back to the origin
  a_level_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && ctl.last_px |=> slot == '0 && !ctl.odd_col && !ctl.odd_row)
    else $error("scan did not wrap after the last pixel");

endmodule

// ===== dv/tb_mipmap_box_filter_downsample_core.sv =====
// Self-checking stream testbench for the 2x2 box-filter mip level reducer.
`timescale 1ns / 1ps

module tb_mipmap_box_filter_downsample_core;

  // Block sizing; the side caps are the largest power of two within each limit.
  localparam int unsigned MaxW        = 1024;
  localparam int unsigned MaxH        = 512;
  localparam int unsigned WCapLg      = $clog2(MaxW);
  localparam int unsigned HCapLg      = $clog2(MaxH);
  localparam int unsigned SlotN       = MaxW / 2;
  localparam logic [mmbf_pkg::LgW-1:0] RstWidthLg  = mmbf_pkg::LgW'(10);
  localparam logic [mmbf_pkg::LgW-1:0] RstHeightLg = mmbf_pkg::LgW'(9);
  localparam logic [mmbf_pkg::LgW-1:0] LgAllOnes   = '1;
  // Cycles to let pass once the last result is in (output register plus slack).
  localparam int unsigned SettleCyc   = 4;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int unsigned LongHoldCyc = 300;
  localparam int unsigned RandTarget  = 200;
  // Short open-level runs at the reset and saturated sizes.
  localparam int unsigned ShortRun    = 16;

  // channel 0 = red, lowest byte
  typedef logic [mmbf_pkg::NumChan-1:0][mmbf_pkg::ChanW-1:0] rgba_t;
  // per-channel horizontal pair sums
  typedef logic [mmbf_pkg::NumChan-1:0][mmbf_pkg::SumW-1:0]  pair_t;
  typedef struct packed {
    rgba_t px;
    logic  done;
  } avg_px_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_we_i      = 1'b0;
  logic                         cfg_idx_i     = mmbf_pkg::RegWidthLog2;
  logic [mmbf_pkg::LgW-1:0]     cfg_data_i    = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [mmbf_pkg::PixW-1:0]    s_axis_tdata  = '0;  // in_red, in_green, in_blue, in_alpha
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [mmbf_pkg::PixW-1:0]    m_axis_tdata;  // out_red, out_green, out_blue, out_alpha
  logic                         m_axis_tlast;  // level_done

  mipmap_box_filter_downsample_core #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin : clk_gen
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Filter predictor state. Owned by the pixel driver process: it sees every
  // accepted pixel and every config write at the same edges as the block.
  // ---------------------------------------------------------------------------
  pair_t                    line_sums [SlotN];  // never read before the row above wrote it
  rgba_t                    held_px   = '0;     // left pixel of the current pair
  int unsigned              col_pos   = 0;
  int unsigned              row_pos   = 0;
  logic [mmbf_pkg::LgW-1:0] width_lg  = RstWidthLg;
  logic [mmbf_pkg::LgW-1:0] height_lg = RstHeightLg;

  rgba_t   pix_q [$];  // pixels waiting to be offered
  avg_px_t avg_q [$];  // averaged pixels still owed by the block

  int unsigned tx_wait     = 0;
  int unsigned tx_idle_max = 0;
  int unsigned rx_wait     = 0;
  int unsigned rx_idle_max = 0;
  int unsigned hold_left   = 0;
  logic        hold_arm    = 1'b0;
  int unsigned err_cnt     = 0;

  string chan_name [mmbf_pkg::NumChan] = '{"out_red", "out_green", "out_blue", "out_alpha"};

  // Zero counts as one; anything past the cap saturates.
  function automatic int unsigned side_of(logic [mmbf_pkg::LgW-1:0] lg,
                                          int unsigned cap_lg);
    int unsigned k;
    k = lg;
    if (k == 0) k = 1;
    if (k > cap_lg) k = cap_lg;
    return 1 << k;
  endfunction

  function automatic void predict_pixel(rgba_t px);
    int unsigned                 w;
    int unsigned                 h;
    int                          c;
    pair_t                       pair;
    avg_px_t                     r;
    logic [mmbf_pkg::QuadW-1:0]  quad;
    w = side_of(width_lg, WCapLg);
    h = side_of(height_lg, HCapLg);
    if ((col_pos & 1) == 0) begin
      held_px = px;
    end else begin
      for (c = 0; c < mmbf_pkg::NumChan; c++) begin
        pair[c] = mmbf_pkg::SumW'(held_px[c]) + mmbf_pkg::SumW'(px[c]);
      end
      if ((row_pos & 1) == 0) begin
        // even row: park the pair sums for the row below
        line_sums[col_pos >> 1] = pair;
      end else begin
        // odd row: 2x2 sum, truncating divide by four
        for (c = 0; c < mmbf_pkg::NumChan; c++) begin
          quad = mmbf_pkg::QuadW'(pair[c]) + mmbf_pkg::QuadW'(line_sums[col_pos >> 1][c]);
          r.px[c] = quad[mmbf_pkg::QuadW-1:2];
        end
        r.done = (col_pos == w - 1) && (row_pos == h - 1);
        avg_q.push_back(r);
      end
    end
    // raster advance; the level wraps onto a fresh one of the same size
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // Any size write restarts the level; the line store keeps its contents.
  function automatic void apply_size(logic idx, logic [mmbf_pkg::LgW-1:0] val);
    if (idx == mmbf_pkg::RegWidthLog2) begin
      width_lg = val;
    end else begin
      height_lg = val;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Mix of full-range, saturated and near-rail channel values.
  function automatic rgba_t rand_px();
    rgba_t p;
    int    c;
    case ($urandom_range(0, 3))
      0: begin
        for (c = 0; c < mmbf_pkg::NumChan; c++) p[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      1: begin
        for (c = 0; c < mmbf_pkg::NumChan; c++) begin
          p[c] = $urandom_range(0, 1) ? mmbf_pkg::ChanW'($urandom_range(252, 255))
                                      : mmbf_pkg::ChanW'($urandom_range(0, 3));
        end
      end
      default: begin
        p = $urandom;
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Pixel driver. Predicts on each accepted word, applies size writes, then
  // either holds the current word, idles for the drawn gap, or offers the next queued pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : pixel_driver
    logic        took;
    int unsigned wait_n;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      tx_wait       <= 0;
      held_px   = '0;
      col_pos   = 0;
      row_pos   = 0;
      width_lg  = RstWidthLg;
      height_lg = RstHeightLg;
    end else begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) predict_pixel(s_axis_tdata);
      // writes only happen while idle, so never on an accepting edge
      if (cfg_we_i) apply_size(cfg_idx_i, cfg_data_i);
      if (!s_axis_tvalid || took) begin
        wait_n = took ? $urandom_range(0, tx_idle_max) : tx_wait;
        if (wait_n == 0 && pix_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pix_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
          tx_wait       <= (wait_n == 0) ? 0 : wait_n - 1;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk_i or negedge rst_ni) begin : rx_hold
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= LongHoldCyc;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each taken word against the oldest expectation,
  // then draw the stall before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : avg_monitor
    logic        took;
    int unsigned wait_n;
    avg_px_t     want;
    rgba_t       got;
    int          c;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      took = m_axis_tvalid && m_axis_tready;
      if (took) begin
        if (avg_q.size() == 0) begin
          $error("unexpected averaged pixel %h last %b", m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          want = avg_q.pop_front();
          got  = m_axis_tdata;
          for (c = 0; c < mmbf_pkg::NumChan; c++) begin
            if (got[c] !== want.px[c]) begin
              $error("%s expected %0d actual %0d", chan_name[c], want.px[c], got[c]);
              err_cnt++;
            end
          end
          if (m_axis_tlast !== want.done) begin
            $error("level_done expected %0d actual %0d", want.done, m_axis_tlast);
            err_cnt++;
          end
        end
      end
      wait_n = took ? $urandom_range(0, rx_idle_max) : rx_wait;
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        rx_wait       <= wait_n;
      end else if (wait_n == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        rx_wait       <= wait_n - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic size_write(logic idx, logic [mmbf_pkg::LgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Idle point: nothing queued or on the bus and no averaged pixel owed.
  // Checked between edges, once the driver's updates have landed.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pix_q.size() != 0 || s_axis_tvalid || avg_q.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pix_q.push_back(rand_px());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned              rand_items;
    int unsigned              phase;
    int unsigned              lvl;
    int unsigned              n;
    logic [mmbf_pkg::LgW-1:0] cur_w;
    logic [mmbf_pkg::LgW-1:0] cur_h;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes (1024 x 512): part of the first row, level left open; the
    // next write must restart it.
    tx_idle_max = 3;
    rx_idle_max = 3;
    queue_random(ShortRun);
    wait_idle();

    // Directed 2x2 levels: rails, truncation and alternating bit patterns.
    size_write(mmbf_pkg::RegWidthLog2, mmbf_pkg::LgW'(1));
    size_write(mmbf_pkg::RegHeightLog2, mmbf_pkg::LgW'(1));
    tx_idle_max = 0;
    rx_idle_max = 0;
    repeat (4) pix_q.push_back(32'hFFFF_FFFF);
    repeat (4) pix_q.push_back(32'h0000_0000);
    repeat (3) pix_q.push_back(32'h0080_FF01);  // sums 3 / 1019 / 515 / 3
    pix_q.push_back(32'h0383_FE00);
    repeat (2) begin
      pix_q.push_back(32'hAA55_AA55);
      pix_q.push_back(32'h55AA_55AA);
    end
    wait_idle();
    // zero sizes behave as one
    size_write(mmbf_pkg::RegWidthLog2, '0);
    size_write(mmbf_pkg::RegHeightLog2, '0);
    pix_q.push_back(32'h0102_0304);
    pix_q.push_back(32'hFEFD_FCFB);
    pix_q.push_back(32'h8000_7F01);
    pix_q.push_back(32'h7FFF_80FE);
    wait_idle();

    // Oversized width saturates at 1024: one full level plus the next one started.
    size_write(mmbf_pkg::RegWidthLog2, LgAllOnes);
    tx_idle_max = 9;
    rx_idle_max = 9;
    queue_random(2 * MaxW + 4);
    wait_idle();

    // Oversized height on a two-wide level: a short run, level left open.
    size_write(mmbf_pkg::RegHeightLog2, LgAllOnes);
    size_write(mmbf_pkg::RegWidthLog2, '0);
    tx_idle_max = 0;
    rx_idle_max = 9;
    queue_random(ShortRun);
    wait_idle();

    // Random phases on small sizes; partial levels are cut short by the
    // next write, which is itself a restart check.
    cur_w      = '0;
    cur_h      = LgAllOnes;
    rand_items = 0;
    phase      = 0;
    while (rand_items < RandTarget) begin
      if (phase == 0) begin
        cur_w = mmbf_pkg::LgW'(2);
        cur_h = mmbf_pkg::LgW'(2);
        size_write(mmbf_pkg::RegWidthLog2, cur_w);
        size_write(mmbf_pkg::RegHeightLog2, cur_h);
      end else begin
        case ($urandom_range(0, 3))
          1: begin
            cur_w = mmbf_pkg::LgW'($urandom_range(0, 3));
            size_write(mmbf_pkg::RegWidthLog2, cur_w);
          end
          2: begin
            cur_h = mmbf_pkg::LgW'($urandom_range(0, 3));
            size_write(mmbf_pkg::RegHeightLog2, cur_h);
          end
          3: begin
            cur_h = mmbf_pkg::LgW'($urandom_range(0, 3));
            cur_w = mmbf_pkg::LgW'($urandom_range(0, 3));
            size_write(mmbf_pkg::RegHeightLog2, cur_h);
            size_write(mmbf_pkg::RegWidthLog2, cur_w);
          end
          default: begin
            // no write: carry on inside the current level
          end
        endcase
      end
      // saturated height from the previous part would make long levels
      if (cur_h > mmbf_pkg::LgW'(5)) begin
        cur_h = mmbf_pkg::LgW'(3);
        size_write(mmbf_pkg::RegHeightLog2, cur_h);
      end
      lvl = side_of(cur_w, WCapLg) * side_of(cur_h, HCapLg);

      if (phase == 0) begin
        // back-to-back pixels into a receiver that stops taking words
        tx_idle_max = 0;
        rx_idle_max = 0;
        n = 4 * lvl;
        queue_random(n);
        @(posedge clk_i);
        hold_arm <= 1'b1;
        @(posedge clk_i);
        hold_arm <= 1'b0;
      end else begin
        tx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
        n = $urandom_range(lvl / 2, 2 * lvl) + 1;
        if (phase == 1 || $urandom_range(0, 7) == 0) begin
          // sender stops mid-level until every owed pixel is out
          queue_random(n / 2);
          wait_idle();
          queue_random(n - n / 2);
        end else begin
          queue_random(n);
        end
      end
      wait_idle();
      rand_items += n;
      phase++;
    end

    wait_idle();
    repeat (4 * SettleCyc) @(posedge clk_i);
    if (avg_q.size() != 0) $error("%0d averaged pixels never arrived", avg_q.size());
    if (err_cnt == 0 && avg_q.size() == 0) begin
      $display("tb_mipmap_box_filter_downsample_core: PASS");
    end else begin
      $display("tb_mipmap_box_filter_downsample_core: FAIL");
    end
    $finish;
  end

  // Watchdog: well above the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("tb_mipmap_box_filter_downsample_core: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
sv/mmbf_pkg.sv
sv/mmbf_line_store.sv
sv/mmbf_scan_ctl.sv
sv/mipmap_box_filter_downsample_core.sv
dv/tb_mipmap_box_filter_downsample_core.sv
